// ===== design/budgeted_tile_region_fill_defines.svh =====
// assertion macros shared by the tile region fill modules
`ifndef BUDGETED_TILE_REGION_FILL_DEFINES_SVH
`define BUDGETED_TILE_REGION_FILL_DEFINES_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define BTRF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tile region fill check failed");

// next-cycle implication, sampled on aclk, off while aresetn is low
`define BTRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tile region fill check failed");

`endif

// ===== design/btrf_pkg.sv =====
// shared constants, types and helpers for the tile region fill block
`default_nettype none

package btrf_pkg;

    localparam int MAX_RADIUS   = 8;
    localparam int WINDOW_SIDE  = 32;  // power of two
    localparam int COORD_BITS   = 16;

    localparam int WIN_BITS     = $clog2(WINDOW_SIDE);
    localparam int SLOT_BITS    = 2 * WIN_BITS;
    localparam int SLOT_COUNT   = WINDOW_SIDE * WINDOW_SIDE;
    localparam int TAG_BITS     = 2 * COORD_BITS;
    localparam int ENTRY_BITS   = TAG_BITS + 1;

    localparam int IN_BITS      = 16;
    localparam int RAD_BITS     = 4;
    localparam int SPAN_BITS    = $clog2(2 * MAX_RADIUS + 1);
    localparam int BUDGET_BITS  = 10;
    localparam int COUNT_BITS   = 9;

    localparam logic [BUDGET_BITS-1:0] BUDGET_RESET = BUDGET_BITS'(24);
    localparam int PRUNE_MARGIN = 2;
    localparam int MIN_KEEP_RAD = 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_GAP,
        ST_PRUNE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_req;
        logic scan_issue;
        logic prune_issue;
        logic clear_issue;
        logic load_result;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic sweep_last;
    } dp_status_t;

    // sign-extend an input coordinate and wrap it to the coordinate width
    function automatic logic [COORD_BITS-1:0] wrap_in(input logic signed [IN_BITS-1:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        return e[COORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/btrf_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none

module btrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/btrf_ctrl.sv =====
// sequencing state machine for the tile region fill block
`default_nettype none
`include "budgeted_tile_region_fill_defines.svh"

module btrf_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire btrf_pkg::dp_status_t status,
    output btrf_pkg::ctrl_cmd_t      cmd
);

    btrf_pkg::state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            btrf_pkg::ST_CLEAR:  if (status.sweep_last) state_next = btrf_pkg::ST_IDLE;
            btrf_pkg::ST_IDLE:   if (s_valid) state_next = btrf_pkg::ST_SCAN;
            btrf_pkg::ST_SCAN:   if (status.scan_last) state_next = btrf_pkg::ST_GAP;
            btrf_pkg::ST_GAP:    state_next = btrf_pkg::ST_PRUNE;
            btrf_pkg::ST_PRUNE:  if (status.sweep_last) state_next = btrf_pkg::ST_FINISH;
            btrf_pkg::ST_FINISH: if (out_free) state_next = btrf_pkg::ST_IDLE;
            default:             state_next = btrf_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            btrf_pkg::ST_CLEAR:  cmd.clear_issue = 1'b1;
            btrf_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_req = s_valid;
            end
            btrf_pkg::ST_SCAN:   cmd.scan_issue = 1'b1;
            btrf_pkg::ST_GAP:    cmd = '0;
            btrf_pkg::ST_PRUNE:  cmd.prune_issue = 1'b1;
            btrf_pkg::ST_FINISH: cmd.load_result = out_free;
            default:             cmd = '0;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= btrf_pkg::ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    // the last region tile is always followed by the gap state
    `BTRF_ASSERT_NEXT(a_scan_then_gap, cmd.scan_issue && status.scan_last, state_reg == btrf_pkg::ST_GAP)

endmodule

`default_nettype wire

// ===== design/btrf_dp.sv =====
// scan, budget and prune datapath around the tagged tile store
`default_nettype none
`include "budgeted_tile_region_fill_defines.svh"

module btrf_dp (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire btrf_pkg::ctrl_cmd_t                  cmd,
    output btrf_pkg::dp_status_t                      status,
    input  wire logic signed [btrf_pkg::IN_BITS-1:0]  s_center_x,
    input  wire logic signed [btrf_pkg::IN_BITS-1:0]  s_center_y,
    input  wire logic [btrf_pkg::RAD_BITS-1:0]        s_radius,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [btrf_pkg::BUDGET_BITS-1:0]     cfg_wr_data,
    output logic [btrf_pkg::COUNT_BITS-1:0]           m_built_count,
    output logic                                      m_region_complete
);

    localparam int CB = btrf_pkg::COORD_BITS;
    localparam int WB = btrf_pkg::WIN_BITS;
    localparam int SB = btrf_pkg::SLOT_BITS;
    localparam int TB = btrf_pkg::TAG_BITS;
    localparam int EB = btrf_pkg::ENTRY_BITS;
    localparam int RB = btrf_pkg::RAD_BITS;
    localparam int PB = btrf_pkg::SPAN_BITS;
    localparam int BB = btrf_pkg::BUDGET_BITS;
    localparam int NB = btrf_pkg::COUNT_BITS;

    logic [BB-1:0] budget_reg;
    logic [CB-1:0] cx_reg, cy_reg, base_x_reg, base_y_reg, keep_reg;
    logic [PB-1:0] last_reg;
    logic [PB-1:0] i_reg, i_next, j_reg, j_next;
    logic [BB-1:0] remain_reg;
    logic [NB-1:0] built_reg;
    logic          complete_reg;
    logic [SB-1:0] sweep_reg, sweep_next;

    logic          b_valid_reg;
    logic [CB-1:0] b_tx_reg, b_ty_reg;
    logic [SB-1:0] b_slot_reg;
    logic          c_valid_reg;
    logic [SB-1:0] c_slot_reg;

    logic [RB-1:0] r_sat, r_keep;
    logic [CB-1:0] cx_in, cy_in, tx, ty;
    logic [SB-1:0] scan_slot;
    logic [EB-1:0] rd_data, wr_data;
    logic [SB-1:0] rd_addr, wr_addr;
    logic          rd_en, wr_en;
    logic          hit, unlimited, can_build, build_wr, skip, prune_wr;
    logic [CB-1:0] dx, dy, far_hi;
    logic          far_x, far_y;

    // request setup
    assign cx_in  = btrf_pkg::wrap_in(s_center_x);
    assign cy_in  = btrf_pkg::wrap_in(s_center_y);
    assign r_sat  = (s_radius > RB'(btrf_pkg::MAX_RADIUS)) ? RB'(btrf_pkg::MAX_RADIUS) : s_radius;
    assign r_keep = (r_sat > RB'(btrf_pkg::MIN_KEEP_RAD)) ? r_sat : RB'(btrf_pkg::MIN_KEEP_RAD);

    // region tile addressing
    assign tx        = base_x_reg + CB'(i_reg);
    assign ty        = base_y_reg + CB'(j_reg);
    assign scan_slot = {ty[WB-1:0], tx[WB-1:0]};

    assign status.scan_last  = (i_reg == last_reg) && (j_reg == last_reg);
    assign status.sweep_last = (sweep_reg == SB'(btrf_pkg::SLOT_COUNT - 1));

    always_comb begin
        i_next = i_reg;
        j_next = j_reg;
        if (cmd.load_req) begin
            i_next = '0;
            j_next = '0;
        end else if (cmd.scan_issue) begin
            if (i_reg == last_reg) begin
                i_next = '0;
                j_next = j_reg + PB'(1);
            end else begin
                i_next = i_reg + PB'(1);
            end
        end
    end

    assign sweep_next = (cmd.prune_issue || cmd.clear_issue) ? sweep_reg + SB'(1) : sweep_reg;

    // build decision on the slot read in the previous cycle
    assign unlimited = (budget_reg == '0);
    assign can_build = unlimited || (remain_reg != '0);
    assign hit       = rd_data[TB] && (rd_data[TB-1:0] == {b_ty_reg, b_tx_reg});
    assign build_wr  = b_valid_reg && !hit && can_build;
    assign skip      = b_valid_reg && !hit && !can_build;

    // prune: shortest wrapped distance beyond keep in either axis
    assign dx       = rd_data[CB-1:0] - cx_reg;
    assign dy       = rd_data[TB-1:CB] - cy_reg;
    assign far_hi   = '0 - keep_reg;
    assign far_x    = (dx > keep_reg) && (dx < far_hi);
    assign far_y    = (dy > keep_reg) && (dy < far_hi);
    assign prune_wr = c_valid_reg && rd_data[TB] && (far_x || far_y);

    assign rd_en   = cmd.scan_issue || cmd.prune_issue;
    assign rd_addr = cmd.scan_issue ? scan_slot : sweep_reg;
    assign wr_en   = build_wr || prune_wr || cmd.clear_issue;
    assign wr_addr = build_wr ? b_slot_reg : (prune_wr ? c_slot_reg : sweep_reg);
    assign wr_data = build_wr ? {1'b1, b_ty_reg, b_tx_reg} : '0;

    btrf_ram #(
        .WIDTH (EB),
        .DEPTH (btrf_pkg::SLOT_COUNT)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_reg  <= btrf_pkg::BUDGET_RESET;
            sweep_reg   <= '0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                budget_reg <= cfg_wr_data;
            end
            sweep_reg   <= sweep_next;
            b_valid_reg <= cmd.scan_issue;
            c_valid_reg <= cmd.prune_issue;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        i_reg <= i_next;
        j_reg <= j_next;
        if (cmd.load_req) begin
            cx_reg       <= cx_in;
            cy_reg       <= cy_in;
            base_x_reg   <= cx_in - CB'(r_sat);
            base_y_reg   <= cy_in - CB'(r_sat);
            last_reg     <= PB'({r_sat, 1'b0});
            keep_reg     <= CB'(r_keep) + CB'(btrf_pkg::PRUNE_MARGIN);
            remain_reg   <= budget_reg;
            built_reg    <= '0;
            complete_reg <= 1'b1;
        end else begin
            if (build_wr) begin
                built_reg <= built_reg + NB'(1);
                if (!unlimited) begin
                    remain_reg <= remain_reg - BB'(1);
                end
            end
            if (skip) begin
                complete_reg <= 1'b0;
            end
        end
        b_tx_reg   <= tx;
        b_ty_reg   <= ty;
        b_slot_reg <= scan_slot;
        c_slot_reg <= sweep_reg;
        if (cmd.load_result) begin
            m_built_count     <= built_reg;
            m_region_complete <= complete_reg;
        end
    end

    // one write source per cycle
    `BTRF_ASSERT_NOW(a_one_writer, 1'b1, $onehot0({build_wr, prune_wr, cmd.clear_issue}))
    // scan and prune pipelines never overlap
    `BTRF_ASSERT_NOW(a_no_overlap, b_valid_reg, !c_valid_reg)
    // a limited budget caps the tiles built
    `BTRF_ASSERT_NOW(a_budget_cap, b_valid_reg && !unlimited, BB'(built_reg) <= budget_reg)

endmodule

`default_nettype wire

// ===== design/budgeted_tile_region_fill.sv =====
// top level of the budgeted tile region fill block
// usage:
//   requests enter on the s_ channel (valid/ready): a signed tile centre and a
//   radius, saturated at 8. the block marks absent tiles of the square region
//   as built, row by row, until the build budget runs out (0 = unlimited), then
//   drops every stored tile more than max(1,radius)+2 away from the centre.
//   one result per request leaves on the m_ channel (valid/ready): the count of
//   tiles built and whether the region is complete. the user writes build_budget
//   through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
// timing:
//   after acceptance a request makes one store read per region tile, passes the
//   gap state, reads each slot of the 1024-slot store in the prune sweep and
//   loads its result. one request at a time: a new request is taken only after
//   the current one has loaded its result.
// reset:
//   aresetn low clears the control state and loads a budget of 24; afterwards a
//   clearing pass over all 1024 slots empties the store, with s_ready low.
// stall:
//   the result register lets the next request in while a result waits; a
//   finished request holds until the receiver takes the previous result.
`default_nettype none

module budgeted_tile_region_fill (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [btrf_pkg::IN_BITS-1:0]  s_center_x,
    input  wire logic signed [btrf_pkg::IN_BITS-1:0]  s_center_y,
    input  wire logic [btrf_pkg::RAD_BITS-1:0]        s_radius,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [btrf_pkg::COUNT_BITS-1:0]           m_built_count,
    output logic                                      m_region_complete,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [btrf_pkg::BUDGET_BITS-1:0]     cfg_wr_data
);

    // command and status between sequencer and datapath
    btrf_pkg::ctrl_cmd_t  cmd;
    btrf_pkg::dp_status_t status;

    // state machine: clear pass, accept, scan, gap, prune sweep, result
    btrf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // tile store, region scan with budget, prune compare, result register
    btrf_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_center_x        (s_center_x),
        .s_center_y        (s_center_y),
        .s_radius          (s_radius),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .m_built_count     (m_built_count),
        .m_region_complete (m_region_complete)
    );

endmodule

`default_nettype wire

// ===== tb/btrf_fill_checker.sv =====
`timescale 1ns / 1ps
// request/result checker for the tile region fill block: own store model and in-order compare
module btrf_fill_checker
    import btrf_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic signed [IN_BITS-1:0]    s_center_x,
    input  logic signed [IN_BITS-1:0]    s_center_y,
    input  logic [RAD_BITS-1:0]          s_radius,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [COUNT_BITS-1:0]        m_built_count,
    input  logic                         m_region_complete,
    input  logic                         cfg_wr_en,
    input  logic [BUDGET_BITS-1:0]       cfg_wr_data,
    output int                           pending_results,
    output int                           fail_count
);

    typedef struct packed {
        logic [COUNT_BITS-1:0] built;
        logic                  complete;
    } fill_result_t;

    // mirror of the tagged tile store
    logic                  tile_held [SLOT_COUNT];
    logic [COORD_BITS-1:0] tile_col  [SLOT_COUNT];
    logic [COORD_BITS-1:0] tile_row  [SLOT_COUNT];
    logic [BUDGET_BITS-1:0] budget_reg;

    fill_result_t expected_fills [$];
    fill_result_t want;
    int           result_index;

    initial begin
        pending_results = 0;
        fail_count      = 0;
        result_index    = 0;
    end

    task automatic log_mismatch(input string msg);
        $display("mismatch at %0t, result %0d: %s", $time, result_index, msg);
        fail_count++;
    endtask

    // shortest distance around the coordinate ring
    function automatic longint ring_gap(input logic [COORD_BITS-1:0] a,
                                        input logic [COORD_BITS-1:0] b);
        logic [COORD_BITS-1:0] d;
        longint fwd;
        longint back;
        d    = a - b;
        fwd  = longint'(d);
        back = (longint'(1) << COORD_BITS) - fwd;
        return (fwd < back) ? fwd : back;
    endfunction

    // build the region within budget, then prune far tiles
    function automatic fill_result_t fill_region(input logic signed [IN_BITS-1:0] cx_in,
                                                 input logic signed [IN_BITS-1:0] cy_in,
                                                 input logic [RAD_BITS-1:0] rad_in);
        fill_result_t          res;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] tx;
        logic [COORD_BITS-1:0] ty;
        logic [SLOT_BITS-1:0]  slot;
        int                    rad;
        int                    keep;
        int                    left;
        int                    built;
        int                    i;
        int                    j;
        int                    s;
        logic                  unlimited;
        logic                  complete;

        cx        = COORD_BITS'(cx_in);
        cy        = COORD_BITS'(cy_in);
        rad       = (rad_in > MAX_RADIUS) ? MAX_RADIUS : int'(rad_in);
        unlimited = (budget_reg == '0);
        left      = int'(budget_reg);
        built     = 0;
        complete  = 1'b1;

        for (j = 0; j <= 2 * rad; j++) begin
            ty = cy - COORD_BITS'(rad) + COORD_BITS'(j);
            for (i = 0; i <= 2 * rad; i++) begin
                tx   = cx - COORD_BITS'(rad) + COORD_BITS'(i);
                slot = {ty[WIN_BITS-1:0], tx[WIN_BITS-1:0]};
                if (tile_held[slot] && tile_col[slot] == tx && tile_row[slot] == ty)
                    continue;
                if (!unlimited && left == 0) begin
                    complete = 1'b0;
                    continue;
                end
                if (!unlimited)
                    left--;
                built++;
                tile_held[slot] = 1'b1;
                tile_col[slot]  = tx;
                tile_row[slot]  = ty;
            end
        end

        keep = ((rad > MIN_KEEP_RAD) ? rad : MIN_KEEP_RAD) + PRUNE_MARGIN;
        for (s = 0; s < SLOT_COUNT; s++) begin
            if (tile_held[s] && (ring_gap(tile_col[s], cx) > keep ||
                                 ring_gap(tile_row[s], cy) > keep))
                tile_held[s] = 1'b0;
        end

        res.built    = COUNT_BITS'(built);
        res.complete = complete;
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < SLOT_COUNT; s++)
                tile_held[s] = 1'b0;
            budget_reg = BUDGET_RESET;
            expected_fills.delete();
        end else begin
            if (cfg_wr_en)
                budget_reg = cfg_wr_data;
            if (s_valid && s_ready)
                expected_fills.push_back(fill_region(s_center_x, s_center_y, s_radius));
            if (m_valid && m_ready) begin
                if (expected_fills.size() == 0) begin
                    log_mismatch("result with no request outstanding");
                end else begin
                    want = expected_fills.pop_front();
                    if (m_built_count !== want.built)
                        log_mismatch($sformatf("built_count %0d, expected %0d",
                                               m_built_count, want.built));
                    if (m_region_complete !== want.complete)
                        log_mismatch($sformatf("region_complete %0b, expected %0b",
                                               m_region_complete, want.complete));
                end
                result_index++;
            end
        end
        pending_results <= expected_fills.size();
    end

endmodule

// ===== tb/budgeted_tile_region_fill_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the tile region fill block: request stimulus, budget phases, verdict
module budgeted_tile_region_fill_tb;
    import btrf_pkg::*;

    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_ITEMS    = 84;
    localparam int RESULT_LATENCY = 1315;   // worst request, acceptance to result
    localparam int SETTLE_CYCLES  = RESULT_LATENCY + 100;
    localparam int DIRECTED_COUNT = 17;
    localparam int RAD_TOP        = (1 << RAD_BITS) - 1;

    typedef struct packed {
        logic signed [IN_BITS-1:0] x;
        logic signed [IN_BITS-1:0] y;
        logic [RAD_BITS-1:0]       r;
    } tile_request_t;

    // every block input starts at a known value
    logic                        aclk        = 1'b0;
    logic                        aresetn     = 1'b0;
    logic                        s_valid     = 1'b0;
    logic signed [IN_BITS-1:0]   s_center_x  = '0;
    logic signed [IN_BITS-1:0]   s_center_y  = '0;
    logic [RAD_BITS-1:0]         s_radius    = '0;
    logic                        m_ready     = 1'b0;
    logic                        cfg_wr_en   = 1'b0;
    logic [BUDGET_BITS-1:0]      cfg_wr_data = '0;

    wire                         s_ready;
    wire                         m_valid;
    wire [COUNT_BITS-1:0]        m_built_count;
    wire                         m_region_complete;

    int   pending_results;
    int   fail_count;
    logic calm = 1'b0;   // set for the last phase: no idling on either side

    // current centre of the random walk
    logic signed [IN_BITS-1:0] walk_x = '0;
    logic signed [IN_BITS-1:0] walk_y = '0;

    budgeted_tile_region_fill dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_center_x        (s_center_x),
        .s_center_y        (s_center_y),
        .s_radius          (s_radius),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_built_count     (m_built_count),
        .m_region_complete (m_region_complete),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data)
    );

    btrf_fill_checker fill_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_center_x        (s_center_x),
        .s_center_y        (s_center_y),
        .s_radius          (s_radius),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_built_count     (m_built_count),
        .m_region_complete (m_region_complete),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .pending_results   (pending_results),
        .fail_count        (fail_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // directed requests, run with the reset budget of 24
    tile_request_t directed [DIRECTED_COUNT] = '{
        '{16'sd0,      16'sd0,      4'd0},    // single tile
        '{16'sd0,      16'sd0,      4'd0},    // same tile again, nothing to build
        '{16'sd0,      16'sd0,      4'd1},    // grow around a held tile
        '{16'sd0,      16'sd0,      4'd8},    // budget runs out mid region
        '{16'sd0,      16'sd0,      4'd15},   // radius saturates
        '{16'sh7fff,   16'sh7fff,   4'd3},    // region crosses the top of the range
        '{-16'sh8000,  -16'sh8000,  4'd3},    // wrapped neighbours survive the prune
        '{-16'sh8000,  16'sh7fff,   4'd2},
        '{16'sd100,    16'sd100,    4'd1},
        '{16'sd130,    16'sd100,    4'd1},    // slot taken by a tile 32 columns away
        '{16'sd130,    16'sd100,    4'd0},    // radius 0 still keeps a margin of 3
        '{-16'sd1,     -16'sd1,     4'd12},
        '{-16'sd20000, 16'sd12345,  4'd8},    // far jump, old tiles pruned
        '{-16'sd20000, 16'sd12345,  4'd9},
        '{16'sh5555,   -16'sh5556,  4'd5},    // alternating bit patterns
        '{-16'sh5556,  16'sh5555,   4'd10},
        '{16'sd7,      -16'sd7,     4'd4}
    };

    // result side: random stall bursts, with quiet stretches in between
    initial begin
        bit rest;
        rest = 1'b0;
        @(posedge aclk);
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 199) == 0)
                rest = ~rest;
            if (!calm && !rest && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // present one request and hold it until the block takes it
    task automatic send_request(input tile_request_t req);
        s_valid    <= 1'b1;
        s_center_x <= req.x;
        s_center_y <= req.y;
        s_radius   <= req.r;
        do @(posedge aclk); while (!s_ready);
    endtask

    // sender idle burst, skipped in quiet stretches and in the last phase
    task automatic maybe_pause(input int n);
        if (!calm && (n / 16) % 3 != 2 && $urandom_range(0, 1) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // block is idle once every accepted request has its result back
    task automatic wait_for_results();
        do @(posedge aclk); while (pending_results != 0);
    endtask

    task automatic write_budget(input logic [BUDGET_BITS-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // mostly small regions, a few at and above the saturation point
    function automatic logic [RAD_BITS-1:0] pick_radius();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return RAD_BITS'($urandom_range(0, 4));
        else if (roll < 88)
            return RAD_BITS'($urandom_range(5, MAX_RADIUS));
        return RAD_BITS'($urandom_range(MAX_RADIUS + 1, RAD_TOP));
    endfunction

    // random walk of the centre so that held tiles get reused, overwritten and pruned
    task automatic run_phase(input int count);
        tile_request_t req;
        int            n;
        int            pick;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                // small step: most region tiles already held
                walk_x = walk_x + IN_BITS'($urandom_range(0, 6)) - IN_BITS'(3);
                walk_y = walk_y + IN_BITS'($urandom_range(0, 6)) - IN_BITS'(3);
            end else if (pick < 82) begin
                // jump of 17..40 columns: slots still held by the old tiles
                if ($urandom_range(0, 1) == 1)
                    walk_x = walk_x + IN_BITS'($urandom_range(17, 40));
                else
                    walk_x = walk_x - IN_BITS'($urandom_range(17, 40));
                walk_y = walk_y + IN_BITS'($urandom_range(0, 6)) - IN_BITS'(3);
            end else if (pick < 90) begin
                // park next to the edge of the coordinate range
                walk_x = IN_BITS'(16'h7ff8 + $urandom_range(0, 15));
                if ($urandom_range(0, 1) == 1)
                    walk_y = IN_BITS'(16'h7ff8 + $urandom_range(0, 15));
            end else begin
                walk_x = IN_BITS'($urandom);
                walk_y = IN_BITS'($urandom);
            end
            req.x = walk_x;
            req.y = walk_y;
            req.r = pick_radius();
            maybe_pause(n);
            send_request(req);
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        logic [BUDGET_BITS-1:0] phase_budget [RANDOM_PHASES];
        int                     p;
        int                     k;

        // unlimited, full scale, one tile, then two random settings
        phase_budget[0] = '0;
        phase_budget[1] = '1;
        phase_budget[2] = BUDGET_BITS'(1);
        phase_budget[3] = BUDGET_BITS'($urandom_range(2, 60));
        phase_budget[4] = BUDGET_BITS'($urandom_range(0, (1 << BUDGET_BITS) - 1));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // the block runs its store clearing pass first; requests simply wait for ready
        for (k = 0; k < DIRECTED_COUNT; k++) begin
            maybe_pause(k);
            send_request(directed[k]);
        end
        s_valid <= 1'b0;
        wait_for_results();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            if (p == RANDOM_PHASES - 1)
                calm = 1'b1;
            write_budget(phase_budget[p]);
            run_phase(PHASE_ITEMS);
            wait_for_results();
        end

        // watch for any stray result
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // timeout, several times the slowest correct run
    initial begin
        #25_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
